FILE: hdl/cvpi_pkg.sv
// shared types, constants and control encodings of the cascaded voltage/current loop
package cvpi_pkg;

  // field widths
  localparam int unsigned MV_W      = 12;
  localparam int unsigned VOLT_W    = 23;
  localparam int unsigned CMD_W     = 21;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned SIG_W     = 32;
  localparam int unsigned PWM_W     = 9;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // datapath widths
  localparam int unsigned PROD_W = 64;
  localparam int unsigned ACC_W  = 66;
  localparam int unsigned WIDE_W = 43;

  // program length and step counter
  localparam int unsigned PROG_LEN = 21;
  localparam int unsigned STEP_W   = $clog2(PROG_LEN);

  // fixed-point constants, Q.24 coefficients and Q15.16 limits
  localparam logic signed [SIG_W-1:0] FILT_A        = 32'sd8755787;
  localparam logic signed [SIG_W-1:0] FILT_B        = 32'sd4010715;
  localparam logic signed [SIG_W-1:0] VOLT_SCALE    = 32'sd161794;
  localparam logic signed [SIG_W-1:0] AMP_SCALE     = 32'sd167772;
  localparam logic signed [SIG_W-1:0] AMP_OFFSET_MV = 32'sd2945;
  localparam logic signed [SIG_W-1:0] DUTY_MIN      = 32'sd3277;
  localparam logic signed [SIG_W-1:0] DUTY_MAX      = 32'sd62259;
  localparam logic signed [SIG_W-1:0] PWM_SPAN      = 32'sd511;
  localparam logic signed [SIG_W-1:0] Q16_TWELVE    = 32'sd786432;
  localparam logic signed [SIG_W-1:0] Q16_THREE     = 32'sd196608;

  // register reset values
  localparam logic signed [GAIN_W-1:0] OUTER_NOW_RST   = 32'sd2721600;
  localparam logic signed [GAIN_W-1:0] OUTER_PREV_RST  = 32'sd2684355;
  localparam logic signed [GAIN_W-1:0] OUTER_PREV2_RST = 32'sd0;
  localparam logic signed [GAIN_W-1:0] INNER_NOW_RST   = 32'sd110730;
  localparam logic signed [GAIN_W-1:0] INNER_PREV_RST  = 32'sd0;
  localparam logic signed [GAIN_W-1:0] INNER_PREV2_RST = 32'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_TARGET,
    REG_CURRENT_CEILING,
    REG_OUTER_GAIN_NOW,
    REG_OUTER_GAIN_PREV,
    REG_OUTER_GAIN_PREV2,
    REG_INNER_GAIN_NOW,
    REG_INNER_GAIN_PREV,
    REG_INNER_GAIN_PREV2
  } cfg_reg_t;

  typedef struct packed {
    logic        [VOLT_W-1:0] voltage_target;
    logic        [CMD_W-1:0]  current_ceiling;
    logic signed [GAIN_W-1:0] outer_gain_now;
    logic signed [GAIN_W-1:0] outer_gain_prev;
    logic signed [GAIN_W-1:0] outer_gain_prev2;
    logic signed [GAIN_W-1:0] inner_gain_now;
    logic signed [GAIN_W-1:0] inner_gain_prev;
    logic signed [GAIN_W-1:0] inner_gain_prev2;
  } cfg_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_VSCALE,
    MUL_ASCALE,
    MUL_VY_A,
    MUL_VX_B,
    MUL_VX1_B,
    MUL_AY_A,
    MUL_AX_B,
    MUL_AX1_B,
    MUL_OUT0,
    MUL_OUT1,
    MUL_OUT2,
    MUL_IN0,
    MUL_IN1,
    MUL_IN2
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  // destination of the rescaled accumulator or of a difference
  typedef enum logic [3:0] {
    WB_NONE,
    WB_VX,
    WB_AX,
    WB_VY,
    WB_AY,
    WB_EV,
    WB_CMD,
    WB_EA,
    WB_DUTY
  } wb_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT
  } seq_op_t;

  typedef struct packed {
    seq_op_t seq;
    mul_op_t mul;
    acc_op_t acc;
    wb_op_t  wb;
  } ucode_t;

  typedef struct packed {
    mul_op_t mul;
    acc_op_t acc;
    wb_op_t  wb;
    logic    load;
    logic    commit;
  } dp_ctrl_t;

endpackage

FILE: hdl/cvpi_if.sv
// valid/ready channel interfaces for samples, results and register writes
interface cvpi_in_if;
  import cvpi_pkg::*;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] volt_reading_mv;
  logic [MV_W-1:0] amp_reading_mv;
  modport source (output valid, output volt_reading_mv, output amp_reading_mv, input ready);
  modport sink (input valid, input volt_reading_mv, input amp_reading_mv, output ready);
endinterface

interface cvpi_out_if;
  import cvpi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic        [PWM_W-1:0] pwm_ticks;
  logic signed [SIG_W-1:0] smoothed_voltage;
  logic signed [SIG_W-1:0] smoothed_current;
  logic        [CMD_W-1:0] current_command;
  modport source (output valid, output pwm_ticks, output smoothed_voltage,
                  output smoothed_current, output current_command, input ready);
  modport sink (input valid, input pwm_ticks, input smoothed_voltage,
                input smoothed_current, input current_command, output ready);
endinterface

interface cvpi_cfg_if;
  import cvpi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/cascaded_voltage_current_pi_loop.sv
// top level of the cascaded voltage/current incremental pi loop
//
// one sample beat on "sample" carries the calibrated voltage and current
// readings in millivolts; one result beat on "result" returns the pwm
// compare value, both filtered signals and the clamped current command.
// register writes arrive on "cfg" (index 0..7, ready always high); the user
// must make them while no sample is in flight, the block does not enforce it.
//
// a microprogram of 21 steps runs each sample through one shared 32x32
// multiplier and a 66-bit accumulator: scaling, two low-pass filters, the
// outer voltage loop and the inner current loop, at most one product per step.
// sample.ready is high only in the idle step, so a new sample is taken only
// once the program of the last one has ended and returned to the idle step.
// the sample rate is set by the fourteen products sharing the one multiplier
// plus the error, clamp and write-back steps between them.
//
// reset (rst, synchronous) returns the registers and the loop history to
// their defaults and drops result.valid. a stalled receiver holds the
// result in the output register; the next sample can be taken and worked
// on meanwhile, its last step waits until the output register is free.
module cascaded_voltage_current_pi_loop (
  input  logic        clk,
  input  logic        rst,
  cvpi_in_if.sink     sample,
  cvpi_out_if.source  result,
  cvpi_cfg_if.sink    cfg
);
  import cvpi_pkg::*;

  localparam logic [PWM_W-1:0] PWM_LO = PWM_W'((DUTY_MIN * PWM_SPAN) >>> 16);
  localparam logic [PWM_W-1:0] PWM_HI = PWM_W'((DUTY_MAX * PWM_SPAN) >>> 16);

  cfg_t     cfg_q;
  dp_ctrl_t ctrl;
  logic     in_ready;
  logic     out_free;

  logic        [PWM_W-1:0] dp_pwm;
  logic signed [SIG_W-1:0] dp_volt;
  logic signed [SIG_W-1:0] dp_amp;
  logic        [CMD_W-1:0] dp_cmd;

  cvpi_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  // output register may only be refilled once the last beat has gone
  assign out_free = !result.valid || result.ready;

  cvpi_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  assign sample.ready = in_ready;

  cvpi_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_q            (cfg_q),
    .ctrl             (ctrl),
    .volt_reading_mv  (sample.volt_reading_mv),
    .amp_reading_mv   (sample.amp_reading_mv),
    .pwm_ticks        (dp_pwm),
    .smoothed_voltage (dp_volt),
    .smoothed_current (dp_amp),
    .current_command  (dp_cmd)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctrl.commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      result.pwm_ticks        <= dp_pwm;
      result.smoothed_voltage <= dp_volt;
      result.smoothed_current <= dp_amp;
      result.current_command  <= dp_cmd;
    end
  end

  // a sample beat starts the program, so the idle step is left at once
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample channel still ready right after a sample beat");

  // the duty clamp bounds every pwm value handed out
  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.pwm_ticks >= PWM_LO && result.pwm_ticks <= PWM_HI))
    else $error("pwm value outside the duty clamp");

  // a new result only comes out of the final step, never from the idle step
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!sample.ready))
    else $error("result raised while the sequencer was idle");

endmodule

FILE: hdl/cvpi_cfg_regs.sv
// configuration register file, written through its own channel
module cvpi_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  cvpi_cfg_if.sink       cfg,
  output cvpi_pkg::cfg_t cfg_q
);
  import cvpi_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid & cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.voltage_target   <= VOLT_W'(Q16_TWELVE);
      cfg_q.current_ceiling  <= CMD_W'(Q16_THREE);
      cfg_q.outer_gain_now   <= OUTER_NOW_RST;
      cfg_q.outer_gain_prev  <= OUTER_PREV_RST;
      cfg_q.outer_gain_prev2 <= OUTER_PREV2_RST;
      cfg_q.inner_gain_now   <= INNER_NOW_RST;
      cfg_q.inner_gain_prev  <= INNER_PREV_RST;
      cfg_q.inner_gain_prev2 <= INNER_PREV2_RST;
    end else if (wr) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_VOLTAGE_TARGET:   cfg_q.voltage_target   <= cfg.data[VOLT_W-1:0];
        REG_CURRENT_CEILING:  cfg_q.current_ceiling  <= cfg.data[CMD_W-1:0];
        REG_OUTER_GAIN_NOW:   cfg_q.outer_gain_now   <= $signed(cfg.data);
        REG_OUTER_GAIN_PREV:  cfg_q.outer_gain_prev  <= $signed(cfg.data);
        REG_OUTER_GAIN_PREV2: cfg_q.outer_gain_prev2 <= $signed(cfg.data);
        REG_INNER_GAIN_NOW:   cfg_q.inner_gain_now   <= $signed(cfg.data);
        REG_INNER_GAIN_PREV:  cfg_q.inner_gain_prev  <= $signed(cfg.data);
        REG_INNER_GAIN_PREV2: cfg_q.inner_gain_prev2 <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/cvpi_sequencer.sv
// step counter and microprogram rom driving the loop datapath
module cvpi_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               out_free,
  output logic               in_ready,
  output cvpi_pkg::dp_ctrl_t ctrl
);
  import cvpi_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            word;

  function automatic ucode_t program_word(input logic [STEP_W-1:0] s);
    ucode_t w;
    w = '{seq: SEQ_NEXT, mul: MUL_NONE, acc: ACC_HOLD, wb: WB_NONE};
    case (s)
      STEP_W'(0):  w.seq = SEQ_WAIT_IN;
      // sensor scaling
      STEP_W'(1):  w.mul = MUL_VSCALE;
      STEP_W'(2):  begin w.mul = MUL_ASCALE; w.acc = ACC_LOAD; end
      STEP_W'(3):  begin w.mul = MUL_VY_A;   w.acc = ACC_LOAD; w.wb = WB_VX; end
      // voltage low-pass
      STEP_W'(4):  begin w.mul = MUL_VX_B;   w.acc = ACC_LOAD; w.wb = WB_AX; end
      STEP_W'(5):  begin w.mul = MUL_VX1_B;  w.acc = ACC_ADD; end
      STEP_W'(6):  begin w.mul = MUL_AY_A;   w.acc = ACC_ADD; end
      // current low-pass
      STEP_W'(7):  begin w.mul = MUL_AX_B;   w.acc = ACC_LOAD; w.wb = WB_VY; end
      STEP_W'(8):  begin w.mul = MUL_AX1_B;  w.acc = ACC_ADD;  w.wb = WB_EV; end
      // outer loop
      STEP_W'(9):  begin w.mul = MUL_OUT0;   w.acc = ACC_ADD; end
      STEP_W'(10): begin w.mul = MUL_OUT1;   w.acc = ACC_LOAD; w.wb = WB_AY; end
      STEP_W'(11): begin w.mul = MUL_OUT2;   w.acc = ACC_SUB; end
      STEP_W'(12): w.acc = ACC_ADD;
      STEP_W'(13): w.wb = WB_CMD;
      // inner loop
      STEP_W'(14): w.wb = WB_EA;
      STEP_W'(15): w.mul = MUL_IN0;
      STEP_W'(16): begin w.mul = MUL_IN1;    w.acc = ACC_LOAD; end
      STEP_W'(17): begin w.mul = MUL_IN2;    w.acc = ACC_SUB; end
      STEP_W'(18): w.acc = ACC_ADD;
      STEP_W'(19): w.wb = WB_DUTY;
      STEP_W'(20): w.seq = SEQ_WAIT_OUT;
      default: ;
    endcase
    return w;
  endfunction

  assign word = program_word(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    step_next   = step;
    in_ready    = 1'b0;
    ctrl.mul    = word.mul;
    ctrl.acc    = word.acc;
    ctrl.wb     = word.wb;
    ctrl.load   = 1'b0;
    ctrl.commit = 1'b0;
    unique case (word.seq)
      SEQ_NEXT: begin
        step_next = step + STEP_W'(1);
      end
      SEQ_WAIT_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          step_next = step + STEP_W'(1);
        end
      end
      SEQ_WAIT_OUT: begin
        if (out_free) begin
          ctrl.commit = 1'b1;
          step_next   = '0;
        end
      end
      default: begin
        step_next = '0;
      end
    endcase
  end

endmodule

FILE: hdl/cvpi_datapath.sv
// shared multiplier, accumulator, rescale and clamp logic with loop state
module cvpi_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  cvpi_pkg::cfg_t                      cfg_q,
  input  cvpi_pkg::dp_ctrl_t                  ctrl,
  input  logic        [cvpi_pkg::MV_W-1:0]    volt_reading_mv,
  input  logic        [cvpi_pkg::MV_W-1:0]    amp_reading_mv,
  output logic        [cvpi_pkg::PWM_W-1:0]   pwm_ticks,
  output logic signed [cvpi_pkg::SIG_W-1:0]   smoothed_voltage,
  output logic signed [cvpi_pkg::SIG_W-1:0]   smoothed_current,
  output logic        [cvpi_pkg::CMD_W-1:0]   current_command
);
  import cvpi_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF8  = ACC_W'(1) <<< 7;
  localparam logic signed [ACC_W-1:0] HALF24 = ACC_W'(1) <<< 23;
  localparam int unsigned R24_W = ACC_W - 24;

  // loop state, kept across samples
  logic signed [SIG_W-1:0]  last_volt_sample, last_amp_sample;
  logic signed [SIG_W-1:0]  volt_filter_out, amp_filter_out;
  logic signed [SIG_W-1:0]  volt_err_prev, volt_err_prev2;
  logic signed [SIG_W-1:0]  amp_err_prev, amp_err_prev2;
  logic        [CMD_W-1:0]  amp_command;
  logic        [DUTY_W-1:0] duty_value;

  // per-sample working registers
  logic        [MV_W-1:0]   vmv, amv;
  logic signed [SIG_W-1:0]  vx, ax, vy, ay, ev, ea;
  logic        [CMD_W-1:0]  cmd;
  logic        [DUTY_W-1:0] duty;

  logic signed [SIG_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_rnd8, acc_rnd24;
  logic signed [SIG_W-1:0]  r8;
  logic signed [R24_W-1:0]  r24;
  logic signed [WIDE_W-1:0] ev_diff, ea_diff, cmd_sum, duty_sum;
  logic        [CMD_W-1:0]  cmd_clamped;
  logic        [DUTY_W-1:0] duty_clamped;
  logic        [DUTY_W+PWM_W-1:0] pwm_prod;

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'({1'b0, {(SIG_W-1){1'b1}}});
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return hi[SIG_W-1:0];
    end else if (v < lo) begin
      return lo[SIG_W-1:0];
    end
    return v[SIG_W-1:0];
  endfunction

  // operand selection
  always_comb begin
    unique case (ctrl.mul)
      MUL_VSCALE: begin mul_a = $signed({{(SIG_W-MV_W){1'b0}}, vmv}); mul_b = VOLT_SCALE; end
      MUL_ASCALE: begin
        mul_a = $signed({{(SIG_W-MV_W){1'b0}}, amv}) - AMP_OFFSET_MV;
        mul_b = AMP_SCALE;
      end
      MUL_VY_A:   begin mul_a = volt_filter_out;  mul_b = FILT_A; end
      MUL_VX_B:   begin mul_a = vx;               mul_b = FILT_B; end
      MUL_VX1_B:  begin mul_a = last_volt_sample; mul_b = FILT_B; end
      MUL_AY_A:   begin mul_a = amp_filter_out;   mul_b = FILT_A; end
      MUL_AX_B:   begin mul_a = ax;               mul_b = FILT_B; end
      MUL_AX1_B:  begin mul_a = last_amp_sample;  mul_b = FILT_B; end
      MUL_OUT0:   begin mul_a = ev;               mul_b = cfg_q.outer_gain_now; end
      MUL_OUT1:   begin mul_a = volt_err_prev;    mul_b = cfg_q.outer_gain_prev; end
      MUL_OUT2:   begin mul_a = volt_err_prev2;   mul_b = cfg_q.outer_gain_prev2; end
      MUL_IN0:    begin mul_a = ea;               mul_b = cfg_q.inner_gain_now; end
      MUL_IN1:    begin mul_a = amp_err_prev;     mul_b = cfg_q.inner_gain_prev; end
      MUL_IN2:    begin mul_a = amp_err_prev2;    mul_b = cfg_q.inner_gain_prev2; end
      default:    begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    unique case (ctrl.acc)
      ACC_LOAD: acc <= prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      ACC_SUB:  acc <= acc - prod_ext;
      default:  acc <= acc;
    endcase
  end

  // round to nearest, ties up
  assign acc_rnd8  = acc + HALF8;
  assign acc_rnd24 = acc + HALF24;
  assign r8        = acc_rnd8[SIG_W+7:8];
  assign r24       = acc_rnd24[ACC_W-1:24];

  assign ev_diff  = WIDE_W'($signed({1'b0, cfg_q.voltage_target})) - WIDE_W'(vy);
  assign ea_diff  = WIDE_W'($signed({1'b0, cmd})) - WIDE_W'(ay);
  assign cmd_sum  = WIDE_W'($signed({1'b0, amp_command})) + WIDE_W'(r24);
  assign duty_sum = WIDE_W'($signed({1'b0, duty_value})) + WIDE_W'(r24);

  always_comb begin
    if (cmd_sum > WIDE_W'($signed({1'b0, cfg_q.current_ceiling}))) begin
      cmd_clamped = cfg_q.current_ceiling;
    end else if (cmd_sum < WIDE_W'(0)) begin
      cmd_clamped = '0;
    end else begin
      cmd_clamped = cmd_sum[CMD_W-1:0];
    end
  end

  always_comb begin
    if (duty_sum > WIDE_W'(DUTY_MAX)) begin
      duty_clamped = DUTY_MAX[DUTY_W-1:0];
    end else if (duty_sum < WIDE_W'(DUTY_MIN)) begin
      duty_clamped = DUTY_MIN[DUTY_W-1:0];
    end else begin
      duty_clamped = duty_sum[DUTY_W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vmv <= volt_reading_mv;
      amv <= amp_reading_mv;
    end
    unique case (ctrl.wb)
      WB_VX:   vx   <= r8;
      WB_AX:   ax   <= r8;
      WB_VY:   vy   <= sat_sig(WIDE_W'(r24));
      WB_AY:   ay   <= sat_sig(WIDE_W'(r24));
      WB_EV:   ev   <= sat_sig(ev_diff);
      WB_CMD:  cmd  <= cmd_clamped;
      WB_EA:   ea   <= sat_sig(ea_diff);
      WB_DUTY: duty <= duty_clamped;
      default: ;
    endcase
  end

  // loop state moves forward once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      last_volt_sample <= '0;
      last_amp_sample  <= '0;
      volt_filter_out  <= '0;
      amp_filter_out   <= '0;
      volt_err_prev    <= Q16_TWELVE;
      volt_err_prev2   <= Q16_TWELVE;
      amp_err_prev     <= '0;
      amp_err_prev2    <= '0;
      amp_command      <= CMD_W'(Q16_THREE);
      duty_value       <= '0;
    end else if (ctrl.commit) begin
      last_volt_sample <= vx;
      last_amp_sample  <= ax;
      volt_filter_out  <= vy;
      amp_filter_out   <= ay;
      volt_err_prev2   <= volt_err_prev;
      volt_err_prev    <= ev;
      amp_err_prev2    <= amp_err_prev;
      amp_err_prev     <= ea;
      amp_command      <= cmd;
      duty_value       <= duty;
    end
  end

  // duty * 511 as a shift and subtract
  assign pwm_prod = {duty, {PWM_W{1'b0}}} - {{PWM_W{1'b0}}, duty};

  assign pwm_ticks        = pwm_prod[DUTY_W+PWM_W-1:DUTY_W];
  assign smoothed_voltage = vy;
  assign smoothed_current = ay;
  assign current_command  = cmd;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the cascaded voltage/current pi loop
module tb;
  import cvpi_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int QUIET_LIMIT     = 5000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES    = 40;    // drain time, longer than a sample takes to its result
  localparam int ITEMS_PER_PHASE = 229;
  localparam int PRINT_CAP       = 50;

  // loop arithmetic: filter taps and scales in Q.24, limits in Q15.16
  localparam longint LP_A      = 8755787;
  localparam longint LP_B      = 4010715;
  localparam longint V_PER_MV  = 161794;
  localparam longint A_PER_MV  = 167772;
  localparam longint A_ZERO_MV = 2945;
  localparam longint DUTY_LO   = 3277;
  localparam longint DUTY_HI   = 62259;
  localparam longint PWM_FULL  = 511;
  localparam longint TWELVE_V  = 786432;
  localparam longint THREE_A   = 196608;

  // register defaults after reset
  localparam logic [31:0] OUTER_NOW_DEF  = 32'd2721600;
  localparam logic [31:0] OUTER_PREV_DEF = 32'd2684355;
  localparam logic [31:0] INNER_NOW_DEF  = 32'd110730;

  typedef struct packed {
    logic [MV_W-1:0] volt_mv;
    logic [MV_W-1:0] amp_mv;
  } reading_t;

  typedef struct packed {
    logic        [PWM_W-1:0] pwm_ticks;
    logic signed [SIG_W-1:0] smoothed_voltage;
    logic signed [SIG_W-1:0] smoothed_current;
    logic        [CMD_W-1:0] current_command;
  } loop_out_t;

  // clock and reset, every block input known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // channel drive registers
  logic                 send_valid = 1'b0;
  logic [MV_W-1:0]      send_volt  = '0;
  logic [MV_W-1:0]      send_amp   = '0;
  logic                 take_ready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  cvpi_in_if  sample_ch ();
  cvpi_out_if result_ch ();
  cvpi_cfg_if cfg_ch ();

  assign sample_ch.valid           = send_valid;
  assign sample_ch.volt_reading_mv = send_volt;
  assign sample_ch.amp_reading_mv  = send_amp;
  assign result_ch.ready           = take_ready;
  assign cfg_ch.valid              = cfg_valid;
  assign cfg_ch.index              = cfg_index;
  assign cfg_ch.data               = cfg_data;

  cascaded_voltage_current_pi_loop u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // stimulus and expectation stores
  reading_t  pending_samples[$];
  loop_out_t expected_outputs[$];

  int error_count  = 0;
  int result_count = 0;

  // idling controls, set per phase by the stimulus
  bit sender_idling   = 1'b1;
  bit receiver_idling = 1'b1;
  logic hold_start = 1'b0;
  int   hold_left  = 0;

  // loop model: configuration and history
  cfg_t   loop_cfg;
  longint volt_x_prev, amp_x_prev, volt_y, amp_y;
  longint volt_err_1, volt_err_2, amp_err_1, amp_err_2;
  longint cmd_level, duty_level;

  // random walk levels for plant-like readings
  int walk_v = 1244;
  int walk_a = 2945;

  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint clip_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rescale with round to nearest, ties toward plus infinity
  function automatic longint round_q(input longint v, input int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint as_gain(input logic [GAIN_W-1:0] g);
    return longint'($signed(g));
  endfunction

  // g0*e0 - g1*e1 + g2*e2 from Q40 down to Q16, split so nothing overflows
  function automatic longint pid_increment(input longint g0, input longint e0,
                                           input longint g1, input longint e1,
                                           input longint g2, input longint e2);
    longint p0, p1, p2, whole, frac;
    p0 = g0 * e0;
    p1 = g1 * e1;
    p2 = g2 * e2;
    whole = (p0 >>> 24) - (p1 >>> 24) + (p2 >>> 24);
    frac  = (p0 & 64'sh00FF_FFFF) - (p1 & 64'sh00FF_FFFF) + (p2 & 64'sh00FF_FFFF);
    return whole + ((frac + 64'sh0080_0000) >>> 24);
  endfunction

  task automatic reset_loop_model();
    loop_cfg.voltage_target   = TWELVE_V[VOLT_W-1:0];
    loop_cfg.current_ceiling  = THREE_A[CMD_W-1:0];
    loop_cfg.outer_gain_now   = OUTER_NOW_DEF;
    loop_cfg.outer_gain_prev  = OUTER_PREV_DEF;
    loop_cfg.outer_gain_prev2 = '0;
    loop_cfg.inner_gain_now   = INNER_NOW_DEF;
    loop_cfg.inner_gain_prev  = '0;
    loop_cfg.inner_gain_prev2 = '0;
    volt_x_prev = 0;
    amp_x_prev  = 0;
    volt_y      = 0;
    amp_y       = 0;
    volt_err_1  = TWELVE_V;
    volt_err_2  = TWELVE_V;
    amp_err_1   = 0;
    amp_err_2   = 0;
    cmd_level   = THREE_A;
    duty_level  = 0;
  endtask

  // one accepted sample through scaling, filters, outer and inner loop
  task automatic run_loop_model(input reading_t rd);
    longint vx, ax, vy, ay, ev, ea, cmd, duty, ticks;
    loop_out_t o;
    vx = round_q(longint'(rd.volt_mv) * V_PER_MV, 8);
    ax = round_q((longint'(rd.amp_mv) - A_ZERO_MV) * A_PER_MV, 8);
    vy = clip_s32(round_q(LP_A * volt_y + LP_B * vx + LP_B * volt_x_prev, 24));
    ay = clip_s32(round_q(LP_A * amp_y + LP_B * ax + LP_B * amp_x_prev, 24));

    // outer loop: voltage error moves the current command
    ev  = clip_s32(longint'(loop_cfg.voltage_target) - vy);
    cmd = cmd_level + pid_increment(as_gain(loop_cfg.outer_gain_now), ev,
                                    as_gain(loop_cfg.outer_gain_prev), volt_err_1,
                                    as_gain(loop_cfg.outer_gain_prev2), volt_err_2);
    if (cmd > longint'(loop_cfg.current_ceiling)) cmd = longint'(loop_cfg.current_ceiling);
    if (cmd < 0) cmd = 0;

    // inner loop: current error moves the duty
    ea   = clip_s32(cmd - ay);
    duty = duty_level + pid_increment(as_gain(loop_cfg.inner_gain_now), ea,
                                      as_gain(loop_cfg.inner_gain_prev), amp_err_1,
                                      as_gain(loop_cfg.inner_gain_prev2), amp_err_2);
    if (duty > DUTY_HI) duty = DUTY_HI;
    if (duty < DUTY_LO) duty = DUTY_LO;

    cmd_level   = cmd;
    duty_level  = duty;
    volt_x_prev = vx;
    amp_x_prev  = ax;
    volt_y      = vy;
    amp_y       = ay;
    volt_err_2  = volt_err_1;
    volt_err_1  = ev;
    amp_err_2   = amp_err_1;
    amp_err_1   = ea;

    ticks = (duty * PWM_FULL) >>> 16;
    o.pwm_ticks        = ticks[PWM_W-1:0];
    o.smoothed_voltage = vy[SIG_W-1:0];
    o.smoothed_current = ay[SIG_W-1:0];
    o.current_command  = cmd[CMD_W-1:0];
    expected_outputs.push_back(o);
  endtask

  // sample driver: valid held until the beat, random gaps between beats
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (send_valid && sample_ch.ready) run_loop_model('{send_volt, send_amp});
      if (!send_valid || sample_ch.ready) begin
        if (gap_left != 0) begin
          send_valid <= 1'b0;
          // bursts may chain so gaps reach past the block's busy time
          if (gap_left == 1 && sender_idling && $urandom_range(0, 1) == 0)
            gap_left = $urandom_range(1, 13);
          else
            gap_left--;
        end else if (pending_samples.size() != 0) begin
          reading_t nx;
          nx = pending_samples.pop_front();
          send_valid <= 1'b1;
          send_volt  <= nx.volt_mv;
          send_amp   <= nx.amp_mv;
          if (sender_idling && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 13);
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the stimulus only pulses it
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic check_result();
    loop_out_t want;
    if (expected_outputs.size() == 0) begin
      report_error($sformatf("result beat with nothing expected, pwm_ticks %0d",
                             result_ch.pwm_ticks));
    end else begin
      want = expected_outputs.pop_front();
      result_count++;
      if (result_ch.pwm_ticks !== want.pwm_ticks)
        report_error($sformatf("result %0d pwm_ticks %0d, expected %0d", result_count,
                               result_ch.pwm_ticks, want.pwm_ticks));
      if (result_ch.smoothed_voltage !== want.smoothed_voltage)
        report_error($sformatf("result %0d smoothed_voltage %0d, expected %0d", result_count,
                               result_ch.smoothed_voltage, want.smoothed_voltage));
      if (result_ch.smoothed_current !== want.smoothed_current)
        report_error($sformatf("result %0d smoothed_current %0d, expected %0d", result_count,
                               result_ch.smoothed_current, want.smoothed_current));
      if (result_ch.current_command !== want.current_command)
        report_error($sformatf("result %0d current_command %0d, expected %0d", result_count,
                               result_ch.current_command, want.current_command));
    end
  endtask

  // result monitor: checks each beat, drives ready with random stall bursts
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      take_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && take_ready) check_result();
      if (hold_left != 0) begin
        take_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        take_ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);  // this cycle plus the rest of the burst
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without a beat on any channel ends the run
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((send_valid && sample_ch.ready) || (result_ch.valid && take_ready) ||
                 (cfg_valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one register write beat, model updated when it is taken
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VOLTAGE_TARGET:   loop_cfg.voltage_target   = data[VOLT_W-1:0];
      REG_CURRENT_CEILING:  loop_cfg.current_ceiling  = data[CMD_W-1:0];
      REG_OUTER_GAIN_NOW:   loop_cfg.outer_gain_now   = data;
      REG_OUTER_GAIN_PREV:  loop_cfg.outer_gain_prev  = data;
      REG_OUTER_GAIN_PREV2: loop_cfg.outer_gain_prev2 = data;
      REG_INNER_GAIN_NOW:   loop_cfg.inner_gain_now   = data;
      REG_INNER_GAIN_PREV:  loop_cfg.inner_gain_prev  = data;
      REG_INNER_GAIN_PREV2: loop_cfg.inner_gain_prev2 = data;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [31:0] target, input logic [31:0] ceiling,
                                input logic [31:0] o_now, input logic [31:0] o_prev,
                                input logic [31:0] o_prev2, input logic [31:0] i_now,
                                input logic [31:0] i_prev, input logic [31:0] i_prev2);
    write_reg(REG_VOLTAGE_TARGET, target);
    write_reg(REG_CURRENT_CEILING, ceiling);
    write_reg(REG_OUTER_GAIN_NOW, o_now);
    write_reg(REG_OUTER_GAIN_PREV, o_prev);
    write_reg(REG_OUTER_GAIN_PREV2, o_prev2);
    write_reg(REG_INNER_GAIN_NOW, i_now);
    write_reg(REG_INNER_GAIN_PREV, i_prev);
    write_reg(REG_INNER_GAIN_PREV2, i_prev2);
  endtask

  task automatic queue_sample(input int v, input int a);
    reading_t rd;
    rd.volt_mv = v[MV_W-1:0];
    rd.amp_mv  = a[MV_W-1:0];
    pending_samples.push_back(rd);
  endtask

  function automatic int pin_mv(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // mostly plant-like drifting readings, some noise and rail values
  task automatic queue_random_samples(input int count);
    int pick;
    int rails[4];
    rails = '{0, 4095, 2945, 1244};
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (pick < 3) begin
          walk_v = $urandom_range(0, 4095);
          walk_a = $urandom_range(0, 4095);
        end
        walk_v = pin_mv(walk_v + int'($urandom_range(0, 80)) - 40);
        walk_a = pin_mv(walk_a + int'($urandom_range(0, 80)) - 40);
        queue_sample(walk_v, walk_a);
      end else if (pick < 85) begin
        queue_sample($urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        queue_sample(rails[$urandom_range(0, 3)], rails[$urandom_range(0, 3)]);
      end
    end
  endtask

  // sender pause: everything offered, taken and answered, block back in idle
  task automatic wait_for_idle();
    while (pending_samples.size() != 0 || send_valid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);  // margin after the result beat; the block is already back in its idle step
  endtask

  initial begin
    int phase;
    reset_loop_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed, reset settings: rails, offset point, steady 12 v, bit patterns
    queue_sample(0, 0);
    queue_sample(4095, 4095);
    queue_sample(0, 4095);
    queue_sample(4095, 0);
    repeat (4) queue_sample(1244, 2945);
    queue_sample(2945, 2945);
    queue_sample(1244, 2944);
    queue_sample(1244, 2946);
    queue_sample(12'hAAA, 12'h555);
    queue_sample(12'h555, 12'hAAA);
    queue_sample(1, 1);
    queue_sample(2048, 2048);
    queue_sample(4095, 2945);
    wait_for_idle();

    // all-ones target beyond range, zero ceiling holds the command at 0,
    // largest positive and negative gains
    write_all_regs(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_sample(0, 0);
    queue_sample(4095, 4095);
    queue_sample(0, 4095);
    queue_sample(4095, 0);
    wait_for_idle();

    // zero target, all-ones ceiling, gains mirrored
    write_all_regs(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_sample(4095, 4095);
    queue_sample(0, 0);
    queue_sample(4095, 0);
    queue_sample(0, 4095);
    wait_for_idle();

    // random phases: odd ones but the last take raw 32-bit register words, even ones
    // stay near a working loop, the last reloads the defaults; phase 3 and the last run without idling
    for (phase = 0; phase < 8; phase++) begin
      sender_idling   = (phase != 3) && (phase != 7);
      receiver_idling = sender_idling;
      if (phase == 7)
        write_all_regs(32'(TWELVE_V), 32'(THREE_A), OUTER_NOW_DEF, OUTER_PREV_DEF, 32'h0,
                       INNER_NOW_DEF, 32'h0, 32'h0);
      else if (phase % 2 == 1)
        write_all_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
      else
        write_all_regs($urandom_range(0, 4194304), $urandom_range(0, 1048576),
                       $urandom_range(0, 8000000), $urandom_range(0, 8000000),
                       $urandom_range(0, 400000) - 200000, $urandom_range(0, 400000),
                       $urandom_range(0, 200000), $urandom_range(0, 100000) - 50000);
      queue_random_samples(ITEMS_PER_PHASE);
      if (phase == 2) begin
        // receiver stops while the sender keeps offering, block fills and
        // holds its input off
        @(posedge clk);
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      wait_for_idle();
    end

    // nothing more may come out once the last expectation is met
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
